// ===== hw/rtl/ffha_pkg.sv =====
// Shared constants, types and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES   = 16384;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 8;

  // Offset width, stored size width, rounded request width and walk step counter width.
  localparam int AW    = $clog2(HEAP_BYTES);
  localparam int SW    = AW;
  localparam int NEEDW = AW + 2;
  localparam int STEPW = $clog2(HEAP_BYTES + 3);
  localparam logic [STEPW-1:0] WALK_LIMIT = STEPW'(HEAP_BYTES + 2);

  // Port field widths.
  localparam int KIND_W  = 2;
  localparam int REQ_W   = 15;
  localparam int OFF_W   = 14;
  localparam int BSIZE_W = 15;
  localparam int FRAG_W  = 12;
  localparam int BYTES_W = 15;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_STATS = 2'd3
  } kind_t;

  // Link half of a block header: allocated mark, next-valid bit and next offset.
  typedef struct packed {
    logic          mark;
    logic          lnk;
    logic [AW-1:0] next;
  } link_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_RD_HP, OP_ST_INIT,
    OP_A_FAIL, OP_A_ISSUE, OP_A_TAKE, OP_A_ADV, OP_A_WFP, OP_A_WQ, OP_A_WH,
    OP_F_LATCH, OP_F_ISSUE, OP_F_LOADQ, OP_F_WH, OP_F_WQ, OP_F_NX, OP_F_PREV,
    OP_Q_LOAD, OP_S_ISSUE, OP_S_LOAD, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISP,
    ST_A_LOOP, ST_A_CHK, ST_A_WFP, ST_A_WQ, ST_A_WH,
    ST_F_RDH, ST_F_LOOP, ST_F_RDQ, ST_F_WH, ST_F_WQ, ST_F_NX, ST_F_PREV,
    ST_Q_RD, ST_S_ISSUE, ST_S_LOAD, ST_OUT
  } state_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  p_bad;
    logic  head_lnk;
    logic  q_lnk;
    logic  steps_lim;
    logic  fit;
    logic  split;
    logic  ins;
    logic  merge_next;
    logic  rd_lnk;
  } status_t;

endpackage

// ===== hw/rtl/ffha_ctrl.sv =====
// Controller state machine that sequences the allocator datapath.
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output op_t     op
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_ACCEPT;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts.kind)
          KIND_ALLOC: state_nxt = ST_A_LOOP;
          KIND_FREE: begin
            if (sts.p_bad) begin
              state_nxt = ST_OUT;
            end else begin
              op        = OP_RD_HP;
              state_nxt = ST_F_RDH;
            end
          end
          KIND_QUERY: begin
            if (sts.p_bad) begin
              state_nxt = ST_OUT;
            end else begin
              op        = OP_RD_HP;
              state_nxt = ST_Q_RD;
            end
          end
          default: begin
            op        = OP_ST_INIT;
            state_nxt = sts.head_lnk ? ST_S_ISSUE : ST_OUT;
          end
        endcase
      end
      ST_A_LOOP: begin
        if (sts.steps_lim || !sts.q_lnk) begin
          op        = OP_A_FAIL;
          state_nxt = ST_OUT;
        end else begin
          op        = OP_A_ISSUE;
          state_nxt = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (sts.fit) begin
          op        = OP_A_TAKE;
          state_nxt = ST_A_WFP;
        end else begin
          op        = OP_A_ADV;
          state_nxt = ST_A_LOOP;
        end
      end
      ST_A_WFP: begin
        if (sts.split) op = OP_A_WFP;
        state_nxt = ST_A_WQ;
      end
      ST_A_WQ: begin
        op        = OP_A_WQ;
        state_nxt = ST_A_WH;
      end
      ST_A_WH: begin
        op        = OP_A_WH;
        state_nxt = ST_OUT;
      end
      ST_F_RDH: begin
        op        = OP_F_LATCH;
        state_nxt = ST_F_LOOP;
      end
      ST_F_LOOP: begin
        if (sts.steps_lim) begin
          state_nxt = ST_OUT;
        end else if (sts.ins) begin
          state_nxt = ST_F_WH;
        end else if (!sts.q_lnk) begin
          state_nxt = ST_OUT;
        end else begin
          op        = OP_F_ISSUE;
          state_nxt = ST_F_RDQ;
        end
      end
      ST_F_RDQ: begin
        op        = OP_F_LOADQ;
        state_nxt = ST_F_LOOP;
      end
      ST_F_WH: begin
        op        = OP_F_WH;
        state_nxt = ST_F_WQ;
      end
      ST_F_WQ: begin
        op        = OP_F_WQ;
        state_nxt = sts.merge_next ? ST_F_NX : ST_F_PREV;
      end
      ST_F_NX: begin
        op        = OP_F_NX;
        state_nxt = ST_F_PREV;
      end
      ST_F_PREV: begin
        op        = OP_F_PREV;
        state_nxt = ST_OUT;
      end
      ST_Q_RD: begin
        op        = OP_Q_LOAD;
        state_nxt = ST_OUT;
      end
      ST_S_ISSUE: begin
        if (sts.steps_lim) begin
          state_nxt = ST_OUT;
        end else begin
          op        = OP_S_ISSUE;
          state_nxt = ST_S_LOAD;
        end
      end
      ST_S_LOAD: begin
        op        = OP_S_LOAD;
        state_nxt = sts.rd_lnk ? ST_S_ISSUE : ST_OUT;
      end
      ST_OUT: begin
        // The result register is loaded once the previous transfer has left.
        if (!out_valid_r || out_ready) begin
          op        = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// Datapath: header memories, list walk registers, counters and result registers.
module ffha_dp
  import ffha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  op_t                op,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [OFF_W-1:0]   in_block_offset,
  output status_t            sts,
  output logic               out_ok,
  output logic [OFF_W-1:0]   out_data_offset,
  output logic [BSIZE_W-1:0] out_block_size,
  output logic [FRAG_W-1:0]  out_fragments,
  output logic [BYTES_W-1:0] out_free_bytes,
  output logic [BYTES_W-1:0] out_used_bytes
);

  // Header store split into a size memory and a link memory.
  logic [SW-1:0] size_mem [HEAP_BYTES];
  link_t         link_mem [HEAP_BYTES];

  logic          sz_we, lk_we;
  logic [AW-1:0] sz_wa, lk_wa, rd_addr;
  logic [SW-1:0] sz_wd, sz_rd;
  link_t         lk_wd, lk_rd;

  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    sz_rd <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    lk_rd <= link_mem[rd_addr];
  end

  kind_t            kind_r;
  logic [NEEDW-1:0] need_r;
  logic [AW-1:0]    p_r, hp_r, qp_r, q_next_r, h_next_r, clr_r, head_next_r;
  logic [SW-1:0]    q_size_r, h_size_r, bsz_r;
  logic             q_head_r, q_lnk_r, h_lnk_r, head_lnk_r;
  logic [STEPW-1:0] steps_r;
  logic [BYTES_W-1:0] used_r, freeb_r;
  logic             ok_r;
  logic [OFF_W-1:0] data_r;
  logic [BSIZE_W-1:0] bsize_r;
  logic [FRAG_W-1:0] frags_r;

  logic [NEEDW-1:0] need_calc;
  logic [AW+2:0]    fp_w;
  logic [AW+1:0]    lim_h, lim_q;
  logic             split, rd_lnk;
  logic [AW-1:0]    h_next_lnk;

  assign need_calc = (NEEDW'(in_req_size) + NEEDW'(ALIGN_BYTES - 1))
                     & ~NEEDW'(ALIGN_BYTES - 1);
  assign fp_w  = (AW+3)'(hp_r) + (AW+3)'(HEADER_BYTES) + (AW+3)'(need_r);
  assign split = !(((AW+3)'(h_size_r) < (AW+3)'(need_r) + (AW+3)'(HEADER_BYTES))
                   || (fp_w >= (AW+3)'(HEAP_BYTES)));
  assign lim_h = (AW+2)'(hp_r) + (AW+2)'(HEADER_BYTES) + (AW+2)'(h_size_r);
  assign lim_q = (AW+2)'(qp_r) + (AW+2)'(HEADER_BYTES) + (AW+2)'(q_size_r);
  assign rd_lnk = lk_rd.lnk && !lk_rd.mark;
  assign h_next_lnk = q_lnk_r ? q_next_r : '0;

  always_comb begin
    sts.clr_last   = (clr_r == {AW{1'b1}});
    sts.kind       = kind_r;
    sts.p_bad      = (p_r < AW'(HEADER_BYTES));
    sts.head_lnk   = head_lnk_r;
    sts.q_lnk      = q_lnk_r;
    sts.steps_lim  = (steps_r >= WALK_LIMIT);
    sts.fit        = (NEEDW'(sz_rd) >= need_r);
    sts.split      = split;
    sts.ins        = (q_head_r || (hp_r > qp_r)) && (!q_lnk_r || (hp_r < q_next_r));
    sts.merge_next = q_lnk_r && (lim_h == (AW+2)'(q_next_r));
    sts.rd_lnk     = rd_lnk;
  end

  // Memory port control.
  always_comb begin
    sz_we   = 1'b0;
    lk_we   = 1'b0;
    sz_wa   = hp_r;
    lk_wa   = hp_r;
    sz_wd   = '0;
    lk_wd   = '0;
    rd_addr = hp_r;
    case (op)
      OP_CLEAR: begin
        sz_we = 1'b1;
        lk_we = 1'b1;
        sz_wa = clr_r;
        lk_wa = clr_r;
        sz_wd = (clr_r == '0) ? SW'(HEAP_BYTES - HEADER_BYTES) : '0;
      end
      OP_A_ISSUE, OP_F_ISSUE, OP_S_ISSUE: rd_addr = q_next_r;
      OP_A_WFP: begin
        sz_we = 1'b1;
        lk_we = 1'b1;
        sz_wa = fp_w[AW-1:0];
        lk_wa = fp_w[AW-1:0];
        sz_wd = h_size_r - SW'(HEADER_BYTES) - need_r[SW-1:0];
        lk_wd = '{mark: 1'b0, lnk: h_lnk_r, next: h_next_r};
      end
      OP_A_WQ: begin
        lk_we = !q_head_r;
        lk_wa = qp_r;
        lk_wd = split ? '{mark: 1'b0, lnk: 1'b1, next: fp_w[AW-1:0]}
                      : '{mark: 1'b0, lnk: h_lnk_r, next: h_next_r};
      end
      OP_A_WH: begin
        lk_we = 1'b1;
        lk_wd = '{mark: 1'b1, lnk: 1'b0, next: '0};
        sz_we = split;
        sz_wd = need_r[SW-1:0];
      end
      OP_F_WH: begin
        lk_we = 1'b1;
        lk_wd = '{mark: 1'b0, lnk: q_lnk_r, next: h_next_lnk};
      end
      OP_F_WQ: begin
        // The following block is read here for a possible merge.
        rd_addr = q_next_r;
        lk_we   = !q_head_r;
        lk_wa   = qp_r;
        lk_wd   = '{mark: 1'b0, lnk: 1'b1, next: hp_r};
      end
      OP_F_NX: begin
        sz_we = 1'b1;
        lk_we = 1'b1;
        sz_wd = h_size_r + sz_rd + SW'(HEADER_BYTES);
        lk_wd = '{mark: 1'b0, lnk: rd_lnk, next: rd_lnk ? lk_rd.next : '0};
      end
      OP_F_PREV: begin
        // Merge with the preceding free block when it ends where this one starts.
        if (!q_head_r && (lim_q == (AW+2)'(hp_r))) begin
          sz_we = 1'b1;
          lk_we = 1'b1;
        end
        sz_wa = qp_r;
        lk_wa = qp_r;
        sz_wd = q_size_r + h_size_r + SW'(HEADER_BYTES);
        lk_wd = '{mark: 1'b0, lnk: h_lnk_r, next: h_next_r};
      end
      default: ;
    endcase
  end

  // Control state: clearing counter, list head and usage counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      head_lnk_r  <= 1'b1;
      head_next_r <= '0;
      used_r      <= '0;
    end else begin
      case (op)
        OP_CLEAR: clr_r <= clr_r + AW'(1);
        OP_A_WQ: begin
          if (q_head_r) begin
            head_lnk_r  <= split ? 1'b1 : h_lnk_r;
            head_next_r <= split ? fp_w[AW-1:0] : h_next_r;
          end
        end
        OP_A_WH: used_r <= used_r + need_r[BYTES_W-1:0];
        OP_F_WQ: begin
          if (q_head_r) begin
            head_lnk_r  <= 1'b1;
            head_next_r <= hp_r;
          end
        end
        OP_F_PREV: used_r <= used_r - BYTES_W'(bsz_r);
        default: ;
      endcase
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        kind_r   <= kind_t'(in_kind);
        need_r   <= need_calc;
        p_r      <= in_block_offset;
        hp_r     <= in_block_offset - AW'(HEADER_BYTES);
        q_head_r <= 1'b1;
        q_lnk_r  <= head_lnk_r;
        q_next_r <= head_next_r;
        q_size_r <= '0;
        qp_r     <= '0;
        steps_r  <= '0;
        ok_r     <= 1'b1;
        data_r   <= '0;
        bsize_r  <= '0;
        frags_r  <= '0;
        freeb_r  <= '0;
      end
      OP_ST_INIT: begin
        frags_r <= FRAG_W'(1);
        steps_r <= STEPW'(1);
      end
      OP_A_FAIL: begin
        ok_r   <= 1'b0;
        data_r <= '0;
      end
      OP_A_ISSUE: begin
        hp_r    <= q_next_r;
        steps_r <= steps_r + STEPW'(1);
      end
      OP_A_TAKE: begin
        h_size_r <= sz_rd;
        h_lnk_r  <= rd_lnk;
        h_next_r <= lk_rd.next;
      end
      OP_A_ADV, OP_F_LOADQ: begin
        if (op == OP_A_ADV) qp_r <= hp_r;
        q_head_r <= 1'b0;
        q_lnk_r  <= rd_lnk;
        q_next_r <= lk_rd.next;
        q_size_r <= sz_rd;
      end
      OP_A_WH: begin
        ok_r   <= 1'b1;
        data_r <= hp_r + OFF_W'(HEADER_BYTES);
      end
      OP_F_LATCH: begin
        bsz_r    <= sz_rd;
        h_size_r <= sz_rd;
      end
      OP_F_ISSUE: begin
        qp_r    <= q_next_r;
        steps_r <= steps_r + STEPW'(1);
      end
      OP_F_WH: begin
        h_lnk_r  <= q_lnk_r;
        h_next_r <= h_next_lnk;
      end
      OP_F_NX: begin
        h_size_r <= h_size_r + sz_rd + SW'(HEADER_BYTES);
        h_lnk_r  <= rd_lnk;
        h_next_r <= rd_lnk ? lk_rd.next : '0;
      end
      OP_Q_LOAD: begin
        if (lk_rd.mark) bsize_r <= BSIZE_W'(sz_rd);
      end
      OP_S_ISSUE: steps_r <= steps_r + STEPW'(1);
      OP_S_LOAD: begin
        freeb_r  <= freeb_r + BYTES_W'(sz_rd);
        frags_r  <= frags_r + FRAG_W'(1);
        q_next_r <= lk_rd.next;
      end
      OP_OUT: begin
        out_ok          <= ok_r;
        out_data_offset <= data_r;
        out_block_size  <= bsize_r;
        out_fragments   <= frags_r;
        out_free_bytes  <= freeb_r;
        out_used_bytes  <= used_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with address-ordered free list.
//
//   Channel | Direction | Ports
//   in      | input     | in_valid, in_ready, in_kind, in_req_size, in_block_offset
//   out     | output    | out_valid, out_ready, out_ok, out_data_offset, out_block_size,
//           |           | out_fragments, out_free_bytes, out_used_bytes
//
// After reset a clearing pass writes all 16384 header entries, one per cycle,
// and no request is taken until it ends.
// A request walks the free list one entry at a time, each read going through the single
// read port of the header memories, and then writes the headers that it changes.
// The next request is taken while a result still waits for its transfer.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [REQ_W-1:0]   in_req_size,
  input  logic [OFF_W-1:0]   in_block_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [OFF_W-1:0]   out_data_offset,
  output logic [BSIZE_W-1:0] out_block_size,
  output logic [FRAG_W-1:0]  out_fragments,
  output logic [BYTES_W-1:0] out_free_bytes,
  output logic [BYTES_W-1:0] out_used_bytes
);

  status_t sts;
  op_t     op;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .op        (op)
  );

  ffha_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .in_kind         (in_kind),
    .in_req_size     (in_req_size),
    .in_block_offset (in_block_offset),
    .sts             (sts),
    .out_ok          (out_ok),
    .out_data_offset (out_data_offset),
    .out_block_size  (out_block_size),
    .out_fragments   (out_fragments),
    .out_free_bytes  (out_free_bytes),
    .out_used_bytes  (out_used_bytes)
  );

  // One request at a time: an accepted request drops ready for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an input transfer");

  // A failed allocation never reports a data offset.
  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_data_offset == '0)
    else $error("failed allocation carries a nonzero offset");

  // A result is loaded only when the controller leaves its result state.
  a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_OUT |=> out_valid && in_ready)
    else $error("result load did not raise valid and return to idle");

  // A request is latched only on an input transfer.
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_ACCEPT |-> in_valid && in_ready)
    else $error("request latched without an input transfer");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the first-fit heap allocator with a built-in heap predictor.
`timescale 1ns / 1ps

module testbench;
  import ffha_pkg::*;

  localparam int unsigned HEAD_SLOT  = HEAP_BYTES;
  localparam int unsigned WALK_STEPS = HEAP_BYTES + 2;
  localparam bit [1:0]    LINKED     = 2'b01;
  localparam bit [1:0]    MARKED     = 2'b10;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          LONG_HOLD   = 600;

  typedef struct packed {
    logic               ok;
    logic [OFF_W-1:0]   data_offset;
    logic [BSIZE_W-1:0] block_size;
    logic [FRAG_W-1:0]  fragments;
    logic [BYTES_W-1:0] free_bytes;
    logic [BYTES_W-1:0] used_bytes;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [REQ_W-1:0]   in_req_size = '0;
  logic [OFF_W-1:0]   in_block_offset = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [OFF_W-1:0]   out_data_offset;
  logic [BSIZE_W-1:0] out_block_size;
  logic [FRAG_W-1:0]  out_fragments;
  logic [BYTES_W-1:0] out_free_bytes;
  logic [BYTES_W-1:0] out_used_bytes;

  // Predicted heap: header sizes, links and flags, plus the head slot.
  int unsigned hdr_size [HEAP_BYTES+1];
  int unsigned hdr_next [HEAP_BYTES+1];
  bit [1:0]    hdr_flag [HEAP_BYTES+1];
  int unsigned used_total;

  heap_result_t pending_results[$];
  int unsigned  live_blocks[$];
  int           error_count = 0;
  int           sent_per_kind[4] = '{0, 0, 0, 0};
  int           checked_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_token = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           cycle_count = 0;

  first_fit_heap_allocator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_req_size(in_req_size), .in_block_offset(in_block_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_data_offset(out_data_offset), .out_block_size(out_block_size),
    .out_fragments(out_fragments), .out_free_bytes(out_free_bytes),
    .out_used_bytes(out_used_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit link_ok(int unsigned n);
    return (hdr_flag[n] & (LINKED | MARKED)) == LINKED;
  endfunction

  function automatic void put_link(int unsigned n, bit valid, int unsigned to);
    hdr_flag[n] = valid ? LINKED : 2'b00;
    hdr_next[n] = valid ? to : 0;
  endfunction

  function automatic longint unsigned block_end(int unsigned n);
    return longint'(n) + HEADER_BYTES + hdr_size[n];
  endfunction

  function automatic void heap_init();
    for (int i = 0; i <= HEAP_BYTES; i++) begin
      hdr_size[i] = 0;
      hdr_next[i] = 0;
      hdr_flag[i] = 0;
    end
    hdr_size[0] = HEAP_BYTES - HEADER_BYTES;
    put_link(HEAD_SLOT, 1'b1, 0);
    used_total = 0;
  endfunction

  function automatic bit alloc_first_fit(int unsigned req, output int unsigned data);
    int unsigned need, qp, hp, nx, steps;
    longint unsigned fp;
    bit nh;
    need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    qp = HEAD_SLOT;
    steps = 0;
    data = 0;
    while (steps < WALK_STEPS && link_ok(qp)) begin
      hp = hdr_next[qp];
      steps++;
      if (hdr_size[hp] >= need) begin
        fp = longint'(hp) + HEADER_BYTES + need;
        nh = link_ok(hp);
        nx = hdr_next[hp];
        // A remainder too small for a header, or past the heap end, goes out whole.
        if (longint'(hdr_size[hp]) < longint'(need) + HEADER_BYTES || fp >= HEAP_BYTES) begin
          put_link(qp, nh, nx);
        end else begin
          put_link(int'(fp), nh, nx);
          hdr_size[fp] = hdr_size[hp] - HEADER_BYTES - need;
          put_link(qp, 1'b1, int'(fp));
          hdr_size[hp] = need;
        end
        hdr_flag[hp] = MARKED;
        hdr_next[hp] = 0;
        used_total += need;
        data = hp + HEADER_BYTES;
        return 1'b1;
      end
      qp = hp;
    end
    return 1'b0;
  endfunction

  function automatic void free_and_merge(int unsigned p);
    int unsigned hp, qp, nx, bsz;
    bit qn, after_q, before_next;
    if (p < HEADER_BYTES || p - HEADER_BYTES >= HEAP_BYTES) return;
    hp = p - HEADER_BYTES;
    bsz = hdr_size[hp];
    qp = HEAD_SLOT;
    for (int steps = 0; steps < WALK_STEPS; steps++) begin
      qn = link_ok(qp);
      after_q = (qp == HEAD_SLOT) || (hp > qp);
      before_next = !qn || (hp < hdr_next[qp]);
      if (after_q && before_next) begin
        nx = hdr_next[qp];
        put_link(hp, qn, nx);
        put_link(qp, 1'b1, hp);
        if (qn && block_end(hp) == nx) begin
          hdr_size[hp] += hdr_size[nx] + HEADER_BYTES;
          put_link(hp, link_ok(nx), hdr_next[nx]);
        end
        if (qp != HEAD_SLOT && block_end(qp) == hp) begin
          hdr_size[qp] += hdr_size[hp] + HEADER_BYTES;
          put_link(qp, link_ok(hp), hdr_next[hp]);
        end
        used_total -= bsz;
        return;
      end
      if (!qn) return;
      qp = hdr_next[qp];
    end
  endfunction

  function automatic heap_result_t predict_request(kind_t kind, int unsigned req,
                                                   int unsigned off);
    heap_result_t r;
    int unsigned data, n, frags, freeb;
    r = '0;
    r.ok = 1'b1;
    case (kind)
      KIND_ALLOC: begin
        r.ok = alloc_first_fit(req, data);
        r.data_offset = data[OFF_W-1:0];
      end
      KIND_FREE: free_and_merge(off);
      KIND_QUERY: begin
        if (off >= HEADER_BYTES && off - HEADER_BYTES < HEAP_BYTES)
          if (hdr_flag[off - HEADER_BYTES] & MARKED)
            r.block_size = hdr_size[off - HEADER_BYTES][BSIZE_W-1:0];
      end
      default: begin
        n = HEAD_SLOT;
        frags = 0;
        freeb = 0;
        for (int steps = 0; steps < WALK_STEPS; steps++) begin
          freeb += hdr_size[n];
          frags++;
          if (!link_ok(n)) break;
          n = hdr_next[n];
        end
        r.fragments = frags[FRAG_W-1:0];
        r.free_bytes = freeb[BYTES_W-1:0];
      end
    endcase
    r.used_bytes = used_total[BYTES_W-1:0];
    return r;
  endfunction

  // Offers one request, waits for its transfer and records what must come back.
  task automatic send_request(kind_t kind, int unsigned req, int unsigned off);
    heap_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_req_size <= req[REQ_W-1:0];
    in_block_offset <= off[OFF_W-1:0];
    do @(posedge clk); while (!in_ready);
    r = predict_request(kind, req & 32'h7fff, off & 32'h3fff);
    pending_results.push_back(r);
    sent_per_kind[kind]++;
    if (kind == KIND_ALLOC && r.ok) live_blocks.push_back(r.data_offset);
  endtask

  task automatic free_live(int idx);
    int unsigned off;
    off = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(KIND_FREE, 0, off);
  endtask

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    heap_result_t w;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, used_bytes", out_used_bytes, 0);
      end else begin
        w = pending_results.pop_front();
        checked_count++;
        if (out_ok !== w.ok) report_mismatch("ok", out_ok, w.ok);
        if (out_data_offset !== w.data_offset)
          report_mismatch("data_offset", out_data_offset, w.data_offset);
        if (out_block_size !== w.block_size)
          report_mismatch("block_size", out_block_size, w.block_size);
        if (out_fragments !== w.fragments)
          report_mismatch("fragments", out_fragments, w.fragments);
        if (out_free_bytes !== w.free_bytes)
          report_mismatch("free_bytes", out_free_bytes, w.free_bytes);
        if (out_used_bytes !== w.used_bytes)
          report_mismatch("used_bytes", out_used_bytes, w.used_bytes);
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, started by a new token from the test sequence.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed_edges();
    int unsigned first_free;
    send_request(KIND_STATS, 0, 0);
    send_request(KIND_ALLOC, 16384, 0);
    send_request(KIND_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);  // whole heap, no room to split
    send_request(KIND_QUERY, 0, HEADER_BYTES);
    send_request(KIND_STATS, 0, 0);
    free_live(0);
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_ALLOC, 9, 0);
    send_request(KIND_ALLOC, 32767, 0);
    send_request(KIND_QUERY, 0, live_blocks[2]);
    send_request(KIND_QUERY, 0, 3);
    send_request(KIND_FREE, 0, 3);           // offset below the header size
    first_free = hdr_next[HEAD_SLOT] + HEADER_BYTES;
    send_request(KIND_FREE, 0, first_free);  // already on the free list
    send_request(KIND_FREE, 0, live_blocks[1]);
    send_request(KIND_FREE, 0, live_blocks[1]);  // second free of the same block
    live_blocks.delete(1);
    send_request(KIND_QUERY, 0, 16383);
    send_request(KIND_STATS, 0, 0);
  endtask

  task automatic test_merging();
    int base;
    base = live_blocks.size();
    repeat (3) send_request(KIND_ALLOC, 40, 0);
    free_live(base);
    free_live(base + 1);
    free_live(base);  // joins both neighbours
    send_request(KIND_STATS, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_token <= hold_token + 1;
    repeat (30) send_request(KIND_ALLOC, $urandom_range(64), 0);
    repeat (10) free_live($urandom_range(live_blocks.size() - 1));
    send_request(KIND_STATS, 0, 0);
  endtask

  task automatic test_random_mix(int idle_pct, int stall_pct, int count);
    int pick;
    int unsigned sz;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 80 && live_blocks.size() == 0)) begin
        sz = $urandom_range(99);
        sz = sz < 80 ? $urandom_range(256) : sz < 97 ? $urandom_range(4096) : $urandom;
        send_request(KIND_ALLOC, sz, 0);
      end else if (pick < 80) begin
        free_live($urandom_range(live_blocks.size() - 1));
      end else if (pick < 82) begin
        send_request(KIND_FREE, 0, $urandom_range(16383));
      end else if (pick < 93) begin
        if (live_blocks.size() > 0 && pick < 89)
          send_request(KIND_QUERY, 0, live_blocks[$urandom_range(live_blocks.size() - 1)]);
        else
          send_request(KIND_QUERY, 0, $urandom_range(16383));
      end else begin
        send_request(KIND_STATS, 0, 0);
      end
    end
  endtask

  initial begin
    heap_init();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_merging();
    test_backpressure();
    test_random_mix(0, 0, 150);
    test_random_mix(72, 0, 150);
    test_random_mix(0, 72, 150);
    test_random_mix(9, 9, 150);
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d allocates, %0d frees, %0d size queries, %0d statistics requests;",
             sent_per_kind[KIND_ALLOC], sent_per_kind[KIND_FREE],
             sent_per_kind[KIND_QUERY], sent_per_kind[KIND_STATS]);
    $display("%0d results checked under four idle and stall mixes and a long hold-off.",
             checked_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
